/* rtl/gwc_pkg.sv */
// Shared types and constants for the gaussian window convolver.
`default_nettype none

package gwc_pkg;

  // Fixed field widths
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int POS_W       = 11;
  localparam int COEF_IDX_W  = 9;
  localparam int COEF_VAL_W  = 16;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int RAD_W       = 4;
  localparam int HEIGHT_W    = 11;
  localparam int MAX_HEIGHT  = 2048;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 12'd800;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 12'd600;
  localparam logic [RAD_W-1:0]      RADIUS_RST = 4'd9;

  // Input item kinds (tuser)
  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Window sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control from sequencer to MAC unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/gaussian_window_convolver.sv */
// Top level: 2-D weighted window blur over BGR pixels with a shared MAC.
//
//  channel   | dir | payload
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | coefficient load (tuser=0) or BGR pixel (tuser=1)
//  m_axis    | out | filtered centre pixel with position, tlast = frame end
//  cfg       | in  | width, height, radius register writes
//
// A pixel that completes an interior window is accepted, then walks it one
// window element per cycle through the single ring read port and the MAC,
// then drains through the read, product and sum registers before the result
// load. Other items need no walk.
// After reset the weight memory is zero-filled with tready low. A waiting
// result sits in the output register while the next item is accepted; a
// newer result holds until it is free.
`default_nettype none

module gaussian_window_convolver #(
  parameter int MAX_RADIUS  = 9,
  parameter int MAX_WIDTH   = 2048,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // s_axis_tdata: coef_index[8:0], coef_value[24:9], in_blue[32:25],
  //               in_green[40:33], in_red[48:41], zero pad
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [gwc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: kind[0]
  input  wire logic [0:0]                     s_axis_tuser,
  // m_axis_tdata: out_x[10:0], out_y[21:11], out_blue[29:22],
  //               out_green[37:30], out_red[45:38], zero pad
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [gwc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [gwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gwc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gwc_pkg::*;

  localparam int GRID_SIDE  = 2 * MAX_RADIUS + 1;
  localparam int GRID_SIZE  = GRID_SIDE * GRID_SIDE;
  localparam int RING_ROWS  = GRID_SIDE;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(RING_ROWS);
  localparam int WAW        = $clog2(GRID_SIZE);
  localparam int SW         = $clog2(GRID_SIDE);
  localparam int LINE_DEPTH = RING_ROWS * (2 ** CW);
  localparam int LAW        = RW + CW;
  localparam int ACC_W      = CH_W + WEIGHT_BITS + $clog2(GRID_SIZE);

  // Configuration registers
  logic [CFG_DATA_W-1:0] cfg_width, cfg_height;
  logic [RAD_W-1:0]      cfg_radius;

  // Clamped working values
  logic [CW:0]           w_eff;
  logic [CFG_DATA_W-1:0] h_eff;
  logic [RAD_W-1:0]      r_eff;
  logic [CW-1:0]         x_last;
  logic [HEIGHT_W-1:0]   y_last;
  logic [SW-1:0]         side;

  // Raster position
  logic [CW-1:0]       x_cnt;
  logic [HEIGHT_W-1:0] y_cnt;
  logic [RW-1:0]       ymod;

  // Window sequencer
  state_t              state, state_next;
  logic [SW-1:0]       sx, sy;
  logic [CW-1:0]       col, xs;
  logic [RW-1:0]       rrow;
  logic [WAW-1:0]      waddr;
  logic                issue_v;
  logic [CW-1:0]       cx;
  logic [HEIGHT_W-1:0] cy;
  logic                cend;

  // Handshake and control
  logic       in_acc, is_pix, emit, cfg_hit;
  logic       issue, load_out, last_col, last_row;
  logic       in_ready;
  mac_ctl_t   mac_ctl;
  logic       mac_pending;
  logic [RW:0] rs_diff;
  logic [RW-1:0] rstart;
  logic [WAW-1:0] wstep;

  // Memory ports
  logic                    wt_we, wt_clearing;
  logic [31:0]             cv_ext;
  logic [WEIGHT_BITS-1:0]  wt_rdata;
  logic [PIX_W-1:0]        pix_rdata;
  logic                    ln_we;

  // Result path
  logic [CH_W-1:0]     res_b, res_g, res_r;
  logic                out_valid;
  logic [POS_W-1:0]    ox, oy;
  logic [CH_W-1:0]     ob, og, orr;
  logic                oend;

  // Clamp registers to their used ranges
  always_comb begin
    if (cfg_width < CFG_DATA_W'(3)) begin
      w_eff = (CW + 1)'(3);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(cfg_width);
    end
    if (cfg_height < CFG_DATA_W'(3)) begin
      h_eff = CFG_DATA_W'(3);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      h_eff = CFG_DATA_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height;
    end
    if (cfg_radius == '0) begin
      r_eff = RAD_W'(1);
    end else if (32'(cfg_radius) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = cfg_radius;
    end
  end

  assign x_last = CW'(w_eff - (CW + 1)'(1));
  assign y_last = HEIGHT_W'(h_eff - CFG_DATA_W'(1));
  assign side   = SW'({r_eff, 1'b0});

  // Input decode
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_pix = (s_axis_tuser[0] == KIND_PIXEL);
  assign emit   = is_pix && (x_cnt >= CW'(side)) && (y_cnt >= HEIGHT_W'(side));

  always_comb begin
    case (cfg_index)
      REG_WIDTH, REG_HEIGHT, REG_RADIUS: cfg_hit = 1'b1;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RST;
      cfg_height <= HEIGHT_RST;
      cfg_radius <= RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width  <= cfg_data;
        REG_HEIGHT: cfg_height <= cfg_data;
        REG_RADIUS: cfg_radius <= cfg_data[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Raster counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      x_cnt <= '0;
      y_cnt <= '0;
      ymod  <= '0;
    end else if (cfg_we && cfg_hit) begin
      x_cnt <= '0;
      y_cnt <= '0;
      ymod  <= '0;
    end else if (in_acc && is_pix) begin
      if (x_cnt >= x_last) begin
        x_cnt <= '0;
        if (y_cnt >= y_last) begin
          y_cnt <= '0;
          ymod  <= '0;
        end else begin
          y_cnt <= y_cnt + 1'b1;
          ymod  <= (ymod == RW'(RING_ROWS - 1)) ? '0 : ymod + 1'b1;
        end
      end else begin
        x_cnt <= x_cnt + 1'b1;
      end
    end
  end

  // First ring row of the window
  always_comb begin
    rs_diff = {1'b0, ymod} - (RW + 1)'(side);
    if (rs_diff[RW]) begin
      rstart = RW'(rs_diff + (RW + 1)'(RING_ROWS));
    end else begin
      rstart = RW'(rs_diff);
    end
  end

  assign last_col = (sx == side);
  assign last_row = (sy == side);
  assign wstep    = WAW'(GRID_SIDE) - WAW'(side);

  // Window walk counters
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      sx    <= '0;
      sy    <= '0;
      col   <= x_cnt - CW'(side);
      xs    <= x_cnt - CW'(side);
      rrow  <= rstart;
      waddr <= '0;
      cx    <= x_cnt;
      cy    <= y_cnt;
      cend  <= (x_cnt == x_last) && (y_cnt == y_last);
    end else if (issue) begin
      if (!last_col) begin
        sx    <= sx + 1'b1;
        col   <= col + 1'b1;
        waddr <= waddr + 1'b1;
      end else if (!last_row) begin
        sx    <= '0;
        sy    <= sy + 1'b1;
        col   <= xs;
        waddr <= waddr + wstep;
        rrow  <= (rrow == RW'(RING_ROWS - 1)) ? '0 : rrow + 1'b1;
      end
    end
  end

  // Read data valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_v <= 1'b0;
    end else begin
      issue_v <= issue;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && emit) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_col && last_row) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!issue_v && !mac_pending) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE:   in_ready = !wt_clearing;
      ST_ISSUE:  issue    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out = !out_valid || m_axis_tready;
      default:   ;
    endcase
  end

  assign s_axis_tready = in_ready;
  assign mac_ctl.clr   = in_acc && emit;
  assign mac_ctl.en    = issue_v;

  // Weight memory
  assign cv_ext = 32'(s_axis_tdata[COEF_IDX_W +: COEF_VAL_W]);
  assign wt_we  = in_acc && !is_pix &&
                  (32'(s_axis_tdata[COEF_IDX_W-1:0]) < GRID_SIZE);

  gwc_weight_ram #(
    .DEPTH (GRID_SIZE),
    .WIDTH (WEIGHT_BITS)
  ) u_weight_ram (
    .clk      (clk),
    .rst      (rst),
    .we       (wt_we),
    .waddr    (WAW'(s_axis_tdata[COEF_IDX_W-1:0])),
    .wdata    (cv_ext[WEIGHT_BITS-1:0]),
    .raddr    (waddr),
    .rdata    (wt_rdata),
    .clearing (wt_clearing)
  );

  // Row ring
  assign ln_we = in_acc && is_pix;

  gwc_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (PIX_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (ln_we),
    .waddr (LAW'({ymod, x_cnt})),
    .wdata (s_axis_tdata[COEF_IDX_W + COEF_VAL_W +: PIX_W]),
    .raddr (LAW'({rrow, col})),
    .rdata (pix_rdata)
  );

  // Shared MAC
  gwc_mac #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .pix     (pix_rdata),
    .wt      (wt_rdata),
    .pending (mac_pending),
    .blue    (res_b),
    .green   (res_g),
    .red     (res_r)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ox   <= POS_W'(cx - CW'(r_eff));
      oy   <= POS_W'(cy - HEIGHT_W'(r_eff));
      ob   <= res_b;
      og   <= res_g;
      orr  <= res_r;
      oend <= cend;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, orr, og, ob, oy, ox};
  assign m_axis_tlast  = oend;

  // MAC pipeline only busy while the window walk is in flight
  a_mac_busy_in_walk: assert property (@(posedge clk) disable iff (rst)
    (issue_v || mac_pending) |-> (state == ST_ISSUE || state == ST_DRAIN))
    else $error("MAC pipeline active outside window walk");

  // No item taken during the weight clear sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    wt_clearing |-> !s_axis_tready)
    else $error("input accepted while weights are clearing");

  // Result loads only after the full window was walked
  a_full_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN || state == ST_FINISH) |-> (last_col && last_row))
    else $error("window walk ended early");

  // An emitting pixel starts a walk on the next cycle
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && emit) |=> (state == ST_ISSUE && sx == '0 && sy == '0))
    else $error("window walk did not start");

endmodule

`default_nettype wire

/* rtl/gwc_weight_ram.sv */
// Kernel weight memory with a zero-fill sweep after reset.
`default_nettype none

module gwc_weight_ram #(
  parameter int DEPTH = 361,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  output logic                          clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_ptr;

  // Clear sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_ptr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_ptr <= clr_ptr + 1'b1;
      end
    end
  end

  // Write port: sweep has priority
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/gwc_line_ram.sv */
// Ring of recent image rows, one write and one registered read port.
`default_nettype none

module gwc_line_ram #(
  parameter int DEPTH  = 38912,
  parameter int WIDTH  = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/gwc_mac.sv */
// Three-channel multiply-accumulate unit with round and saturate.
`default_nettype none

module gwc_mac #(
  parameter int WEIGHT_BITS = 16,
  parameter int ACC_W       = 33
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire gwc_pkg::mac_ctl_t         ctl,
  input  wire logic [gwc_pkg::PIX_W-1:0] pix,
  input  wire logic [WEIGHT_BITS-1:0]    wt,
  output logic                           pending,
  output logic      [gwc_pkg::CH_W-1:0]  blue,
  output logic      [gwc_pkg::CH_W-1:0]  green,
  output logic      [gwc_pkg::CH_W-1:0]  red
);

  import gwc_pkg::*;

  localparam int PROD_W = CH_W + WEIGHT_BITS;

  logic [PROD_W-1:0] prod_b, prod_g, prod_r;
  logic [ACC_W-1:0]  acc_b, acc_g, acc_r;

  // Round half up at the weight point, then clip to 8 bits
  function automatic logic [CH_W-1:0] round_sat(input logic [ACC_W-1:0] a);
    logic [ACC_W:0] s;
    logic [ACC_W:0] hi;
    s  = {1'b0, a} + (ACC_W + 1)'(1 << (WEIGHT_BITS - 1));
    hi = s >> WEIGHT_BITS;
    if (hi > (ACC_W + 1)'(255)) begin
      round_sat = '1;
    end else begin
      round_sat = hi[CH_W-1:0];
    end
  endfunction

  // Product stage
  always_ff @(posedge clk) begin
    prod_b <= PROD_W'(pix[CH_W-1:0]) * PROD_W'(wt);
    prod_g <= PROD_W'(pix[2*CH_W-1:CH_W]) * PROD_W'(wt);
    prod_r <= PROD_W'(pix[3*CH_W-1:2*CH_W]) * PROD_W'(wt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= ctl.en;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_b <= '0;
      acc_g <= '0;
      acc_r <= '0;
    end else if (pending) begin
      acc_b <= acc_b + ACC_W'(prod_b);
      acc_g <= acc_g + ACC_W'(prod_g);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign blue  = round_sat(acc_b);
  assign green = round_sat(acc_g);
  assign red   = round_sat(acc_r);

endmodule

`default_nettype wire
